// File: design/spbl_pkg.sv
package spbl_pkg;

  typedef logic signed [15:0] sample_t;
  typedef logic signed [31:0] acc_t;
  typedef logic signed [23:0] wide_t;

  localparam wide_t SampleMax = 24'sd32767;
  localparam wide_t SampleMin = -24'sd32768;

  // Reciprocals for exact truncating division by 3 and 5.
  // The shift amount is the constant's name suffix.
  localparam logic [29:0] Recip3K31 = 30'd715827883;
  localparam logic [15:0] Recip3K17 = 16'd43691;
  localparam logic [19:0] Recip5K22 = 20'd838861;

  function automatic sample_t clamp16(input wide_t v);
    if (v > SampleMax) begin
      return 16'sh7fff;
    end else if (v < SampleMin) begin
      return -16'sh8000;
    end
    return v[15:0];
  endfunction

  // Integer part of a Q16 value, truncated toward zero.
  function automatic sample_t q16_int(input acc_t st);
    sample_t ip;
    ip = st[31:16];
    if (st[31] && (st[15:0] != 16'h0000)) begin
      ip = ip + 16'sd1;
    end
    return ip;
  endfunction

  // One-pole update: st + (s * 65536 - st) / (24 or 48), truncated toward zero.
  // Both divisors are 8 or 16 times 3, so the magnitude is shifted first.
  function automatic acc_t lp_step(input acc_t st, input sample_t s, input logic div48);
    logic signed [33:0] d;
    logic [32:0] mag;
    logic [29:0] x;
    logic [59:0] p;
    logic [28:0] q;
    acc_t qs;
    d = 34'($signed({s, 16'h0000})) - 34'(st);
    mag = d[33] ? 33'(-d) : 33'(d);
    x = div48 ? 30'(mag >> 4) : 30'(mag >> 3);
    p = x * Recip3K31;
    q = p[59:31];
    qs = {3'b000, q};
    return d[33] ? st - qs : st + qs;
  endfunction

  // s * 24 / 5, truncated toward zero, then saturated.
  function automatic sample_t surr_gain(input sample_t s);
    logic signed [20:0] v;
    logic [19:0] mag;
    logic [39:0] p;
    logic [17:0] q;
    wide_t qs;
    v = 21'($signed({s, 4'h0})) + 21'($signed({s, 3'h0}));
    mag = v[20] ? 20'(-v) : 20'(v);
    p = mag * Recip5K22;
    q = p[39:22];
    qs = {6'b000000, q};
    return clamp16(v[20] ? -qs : qs);
  endfunction

  function automatic sample_t div3_trunc(input sample_t v);
    logic [15:0] mag;
    logic [31:0] p;
    sample_t q;
    mag = v[15] ? 16'(-v) : 16'(v);
    p = mag * Recip3K17;
    q = {1'b0, p[31:17]};
    return v[15] ? -q : q;
  endfunction

endpackage

// File: design/spbl_if.sv
interface spbl_in_if;
  import spbl_pkg::*;
  logic    valid;
  logic    ready;
  sample_t front_left;
  sample_t front_right;
  sample_t center_in;
  sample_t lfe_in;
  sample_t rear_left;
  sample_t rear_right;
  logic    block_end;
  modport source(output valid, front_left, front_right, center_in, lfe_in,
                 rear_left, rear_right, block_end, input ready);
  modport sink(input valid, front_left, front_right, center_in, lfe_in,
               rear_left, rear_right, block_end, output ready);
endinterface

interface spbl_out_if;
  import spbl_pkg::*;
  logic    valid;
  logic    ready;
  sample_t front_left_out;
  sample_t front_right_out;
  sample_t center_out;
  sample_t lfe_out;
  sample_t rear_left_out;
  sample_t rear_right_out;
  logic    block_last;
  modport source(output valid, front_left_out, front_right_out, center_out, lfe_out,
                 rear_left_out, rear_right_out, block_last, input ready);
  modport sink(input valid, front_left_out, front_right_out, center_out, lfe_out,
               rear_left_out, rear_right_out, block_last, output ready);
endinterface

interface spbl_cfg_if;
  logic valid;
  logic ready;
  logic surround_enable;
  modport source(output valid, surround_enable, input ready);
  modport sink(input valid, surround_enable, output ready);
endinterface

// File: design/surround_postmix_bass_lfe_chain.sv
// A frame accepted on the input channel moves through stage 1, stage 2, stage 3 and the
// result register, the fourth register stage, from which it is presented on the result
// channel; throughput is one frame per clock cycle while the result channel is ready.
// The front and LFE filter loops each close through a single reciprocal multiplier.
// Reset (rst_n low at a clock edge) clears all three filter states, surround mode
// and every stage valid; the pipeline payload registers are not reset.
module surround_postmix_bass_lfe_chain (
  input logic         clk,
  input logic         rst_n,
  spbl_in_if.sink     in_ch,
  spbl_out_if.source  out_ch,
  spbl_cfg_if.sink    cfg_ch
);
  import spbl_pkg::*;

  // Control: surround mode and one valid bit per stage.
  logic surround_en_r;
  logic v1_r, v2_r, v3_r, v4_r;
  logic in_fire, take2, take3, take4, cfg_fire;

  // Filter states.
  acc_t bass_acc_l_r, bass_acc_r_r, lfe_acc_r;
  acc_t bass_l_nxt, bass_r_nxt, lfe_nxt;

  // Stage 1: captured frame plus a copy of the updated front filter states.
  sample_t s1_fl_r, s1_fr_r, s1_c_r, s1_lfe_r, s1_rl_r, s1_rr_r;
  acc_t    s1_stl_r, s1_str_r;
  logic    s1_blk_r, s1_surr_r;

  // Stage 2: finished front pair, gained surround channels, mono mix.
  sample_t s2_fl_r, s2_fr_r, s2_c_r, s2_lfe_r, s2_rl_r, s2_rr_r, s2_mono_r;
  logic    s2_blk_r, s2_surr_r;
  sample_t fl_boost, fr_boost, mono_nxt;
  logic signed [16:0] mono_sum, mono_adj;

  // Stage 3: everything but the LFE feed, plus the updated LFE filter state.
  sample_t s3_fl_r, s3_fr_r, s3_c_r, s3_lfe_r, s3_rl_r, s3_rr_r;
  acc_t    s3_st_r;
  logic    s3_blk_r, s3_surr_r;

  // Stage 4: the result register.
  sample_t o_fl_r, o_fr_r, o_c_r, o_lfe_r, o_rl_r, o_rr_r;
  logic    o_blk_r;
  sample_t lfe_fed;

  // Each stage moves forward when it is empty or its own content moves on, so
  // bubbles collapse and a waiting result never blocks the stages behind it
  // from filling up.
  assign take4       = v3_r && (!v4_r || out_ch.ready);
  assign take3       = v2_r && (!v3_r || take4);
  assign take2       = v1_r && (!v2_r || take3);
  assign in_ch.ready = !v1_r || take2;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // The configuration register is always writable.
  assign cfg_ch.ready = 1'b1;
  assign cfg_fire     = cfg_ch.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      surround_en_r <= 1'b0;
      v1_r          <= 1'b0;
      v2_r          <= 1'b0;
      v3_r          <= 1'b0;
      v4_r          <= 1'b0;
      bass_acc_l_r  <= '0;
      bass_acc_r_r  <= '0;
      lfe_acc_r     <= '0;
    end else begin
      if (cfg_fire) begin
        surround_en_r <= cfg_ch.surround_enable;
      end
      v1_r <= in_fire || (v1_r && !take2);
      v2_r <= take2 || (v2_r && !take3);
      v3_r <= take3 || (v3_r && !take4);
      v4_r <= take4 || (v4_r && !out_ch.ready);
      // Each front filter state advances once per transaction; the LFE state only for frames in surround mode.
      if (in_fire) begin
        bass_acc_l_r <= bass_l_nxt;
        bass_acc_r_r <= bass_r_nxt;
      end
      if (take3 && s2_surr_r) begin
        lfe_acc_r <= lfe_nxt;
      end
    end
  end

  // Stage 1: front filter updates straight from the incoming transaction.
  assign bass_l_nxt = lp_step(bass_acc_l_r, in_ch.front_left, 1'b0);
  assign bass_r_nxt = lp_step(bass_acc_r_r, in_ch.front_right, 1'b0);

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_fl_r   <= in_ch.front_left;
      s1_fr_r   <= in_ch.front_right;
      s1_c_r    <= in_ch.center_in;
      s1_lfe_r  <= in_ch.lfe_in;
      s1_rl_r   <= in_ch.rear_left;
      s1_rr_r   <= in_ch.rear_right;
      s1_blk_r  <= in_ch.block_end;
      s1_surr_r <= surround_en_r;
      s1_stl_r  <= bass_l_nxt;
      s1_str_r  <= bass_r_nxt;
    end
  end

  // Stage 2: bass boost and front gain, surround gain, mono average.
  spbl_front_boost u_boost_l (
    .sample_i (s1_fl_r),
    .acc_i    (s1_stl_r),
    .boost_o  (fl_boost)
  );

  spbl_front_boost u_boost_r (
    .sample_i (s1_fr_r),
    .acc_i    (s1_str_r),
    .boost_o  (fr_boost)
  );

  // The mono average truncates toward zero.
  assign mono_sum = 17'(fl_boost) + 17'(fr_boost);
  assign mono_adj = mono_sum + (mono_sum[16] ? 17'sd1 : 17'sd0);
  assign mono_nxt = mono_adj[16:1];

  always_ff @(posedge clk) begin
    if (take2) begin
      s2_fl_r   <= fl_boost;
      s2_fr_r   <= fr_boost;
      s2_c_r    <= s1_surr_r ? surr_gain(s1_c_r) : s1_c_r;
      s2_lfe_r  <= s1_surr_r ? surr_gain(s1_lfe_r) : s1_lfe_r;
      s2_rl_r   <= s1_surr_r ? surr_gain(s1_rl_r) : s1_rl_r;
      s2_rr_r   <= s1_surr_r ? surr_gain(s1_rr_r) : s1_rr_r;
      s2_mono_r <= mono_nxt;
      s2_blk_r  <= s1_blk_r;
      s2_surr_r <= s1_surr_r;
    end
  end

  // Stage 3: the LFE filter update, taken only in surround mode.
  assign lfe_nxt = lp_step(lfe_acc_r, s2_mono_r, 1'b1);

  always_ff @(posedge clk) begin
    if (take3) begin
      s3_fl_r   <= s2_fl_r;
      s3_fr_r   <= s2_fr_r;
      s3_c_r    <= s2_c_r;
      s3_lfe_r  <= s2_lfe_r;
      s3_rl_r   <= s2_rl_r;
      s3_rr_r   <= s2_rr_r;
      s3_st_r   <= lfe_nxt;
      s3_blk_r  <= s2_blk_r;
      s3_surr_r <= s2_surr_r;
    end
  end

  // Stage 4: in surround mode, one third of the LFE filter's integer part is fed into the LFE.
  assign lfe_fed = clamp16(24'(s3_lfe_r) + 24'(div3_trunc(q16_int(s3_st_r))));

  always_ff @(posedge clk) begin
    if (take4) begin
      o_fl_r  <= s3_fl_r;
      o_fr_r  <= s3_fr_r;
      o_c_r   <= s3_c_r;
      o_lfe_r <= s3_surr_r ? lfe_fed : s3_lfe_r;
      o_rl_r  <= s3_rl_r;
      o_rr_r  <= s3_rr_r;
      o_blk_r <= s3_blk_r;
    end
  end

  assign out_ch.valid           = v4_r;
  assign out_ch.front_left_out  = o_fl_r;
  assign out_ch.front_right_out = o_fr_r;
  assign out_ch.center_out      = o_c_r;
  assign out_ch.lfe_out         = o_lfe_r;
  assign out_ch.rear_left_out   = o_rl_r;
  assign out_ch.rear_right_out  = o_rr_r;
  assign out_ch.block_last      = o_blk_r;

  // The LFE filter must hold across frames processed with surround mode off.
  a_lfe_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (take3 && !s2_surr_r) |=> $stable(lfe_acc_r))
    else $error("LFE filter state moved with surround mode off");

  // The front filters advance only when a transaction is accepted.
  a_bass_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_fire |=> ($stable(bass_acc_l_r) && $stable(bass_acc_r_r)))
    else $error("front filter state moved without an input transaction");

  // Surround mode changes only through a configuration write.
  a_cfg_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !cfg_fire |=> $stable(surround_en_r))
    else $error("surround mode changed without a configuration write");

  // An accepted transaction always lands in the first stage.
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> v1_r)
    else $error("accepted transaction lost at the first stage");

  // A frame moved into the result register is presented on the next cycle.
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    take4 |=> v4_r)
    else $error("frame moved into the result register was dropped");

endmodule

// File: design/spbl_front_boost.sv
module spbl_front_boost (
  input  spbl_pkg::sample_t sample_i,
  input  spbl_pkg::acc_t    acc_i,
  output spbl_pkg::sample_t boost_o
);
  import spbl_pkg::*;

  sample_t ip;
  logic signed [17:0] t3;
  logic signed [17:0] t3_adj;
  sample_t boosted;

  // Three quarters of the filter's integer part, truncated toward zero.
  assign ip      = q16_int(acc_i);
  assign t3      = 18'(ip) + 18'($signed({ip, 1'b0}));
  assign t3_adj  = t3 + (t3[17] ? 18'sd3 : 18'sd0);
  assign boosted = clamp16(24'(sample_i) + 24'($signed(t3_adj[17:2])));
  assign boost_o = clamp16(24'($signed({boosted, 2'b00})));

endmodule

// File: sim/postmix_check_pkg.sv
`timescale 1ns / 1ps

package postmix_check_pkg;
  import spbl_pkg::sample_t;

  localparam longint SampleHi = 32767;
  localparam longint SampleLo = -32768;
  localparam longint Q16One = 65536;
  localparam longint BassDiv = 24;
  localparam longint LfeDiv = 48;
  localparam longint FrontGain = 4;
  localparam longint SurrNum = 6;
  localparam longint SurrDen = 5;
  localparam longint BassNum = 3;
  localparam longint BassDen = 4;
  localparam longint FeedDen = 3;
  localparam int PrintCap = 40;

  // One 5.1 frame, used for both the input and the result side.
  typedef struct packed {
    sample_t front_left;
    sample_t front_right;
    sample_t center;
    sample_t lfe;
    sample_t rear_left;
    sample_t rear_right;
    logic    marker;
  } frame_t;

  function automatic longint sat16(input longint v);
    if (v > SampleHi) return SampleHi;
    if (v < SampleLo) return SampleLo;
    return v;
  endfunction

  class postmix_tracker;
    bit     surround_on;
    longint acc_left;
    longint acc_right;
    longint acc_lfe;
    frame_t pending_mixes[$];
    int     mismatches;
    int     results_seen;

    function new();
      surround_on = 1'b0;
      acc_left = 0;
      acc_right = 0;
      acc_lfe = 0;
      mismatches = 0;
      results_seen = 0;
    endfunction

    function void set_surround(bit en);
      surround_on = en;
    endfunction

    function int pending();
      return pending_mixes.size();
    endfunction

    // Bass filter update, additive boost of three quarters of the filter's
    // integer part, then a gain of four. All divisions truncate toward zero.
    function longint front_step(input longint s, inout longint acc);
      longint boosted;
      acc = acc + (s * Q16One - acc) / BassDiv;
      boosted = sat16(s + (acc / Q16One) * BassNum / BassDen);
      return sat16(boosted * FrontGain);
    endfunction

    function longint surround_scale(input longint s);
      return sat16(s * FrontGain * SurrNum / SurrDen);
    endfunction

    function void note_frame(frame_t f);
      frame_t mix;
      longint fl;
      longint fr;
      longint mono;
      mix = f;
      fl = front_step(f.front_left, acc_left);
      fr = front_step(f.front_right, acc_right);
      mix.front_left = sample_t'(fl);
      mix.front_right = sample_t'(fr);
      if (surround_on) begin
        mix.center = sample_t'(surround_scale(f.center));
        mix.rear_left = sample_t'(surround_scale(f.rear_left));
        mix.rear_right = sample_t'(surround_scale(f.rear_right));
        mono = (fl + fr) / 2;
        acc_lfe = acc_lfe + (mono * Q16One - acc_lfe) / LfeDiv;
        mix.lfe = sample_t'(sat16(surround_scale(f.lfe) + (acc_lfe / Q16One) / FeedDen));
      end
      pending_mixes.push_back(mix);
    endfunction

    task report_mismatch(string what, longint got, longint want);
      if (mismatches < PrintCap) begin
        $display("[%0t] result %0d: %s got %0d, expected %0d",
                 $time, results_seen, what, got, want);
      end
      mismatches++;
    endtask

    task check_mix(frame_t got);
      frame_t want;
      results_seen++;
      if (pending_mixes.size() == 0) begin
        report_mismatch("unexpected result, front_left", got.front_left, 0);
        return;
      end
      want = pending_mixes.pop_front();
      if (got.front_left !== want.front_left)
        report_mismatch("front_left", got.front_left, want.front_left);
      if (got.front_right !== want.front_right)
        report_mismatch("front_right", got.front_right, want.front_right);
      if (got.center !== want.center)
        report_mismatch("center", got.center, want.center);
      if (got.lfe !== want.lfe)
        report_mismatch("lfe", got.lfe, want.lfe);
      if (got.rear_left !== want.rear_left)
        report_mismatch("rear_left", got.rear_left, want.rear_left);
      if (got.rear_right !== want.rear_right)
        report_mismatch("rear_right", got.rear_right, want.rear_right);
      if (got.marker !== want.marker)
        report_mismatch("block_last", got.marker, want.marker);
    endtask
  endclass

endpackage

// File: sim/tb_surround_postmix_bass_lfe_chain.sv
`timescale 1ns / 1ps

module tb_surround_postmix_bass_lfe_chain;
  import spbl_pkg::*;
  import postmix_check_pkg::*;

  // Cycles without any transaction on any channel before the run is declared hung.
  // The longest legitimate quiet stretch is a long sender gap or receiver stall
  // plus the four-stage pipeline, so this is far beyond a correct run.
  localparam int QuietLimit = 2000;
  localparam int NumPhases = 8;
  localparam int PhaseItems = 240;
  // Pipeline depth is four stages; waiting past it lets any stray result show up.
  localparam int SettleCycles = 12;

  typedef enum {NearLevel, FullScale, Extreme, ScaleEdge, Quiet} sample_mode_t;

  logic clk = 1'b0;
  logic rst_n;

  // When set, stall_on lets the receiver stall at random and send_idle lets the sender insert random gaps.
  bit stall_on = 1'b0;
  bit send_idle = 1'b0;
  int stall_left = 0;
  int quiet_cycles = 0;

  postmix_tracker tracker;

  spbl_in_if  in_ch();
  spbl_out_if out_ch();
  spbl_cfg_if cfg_ch();

  surround_postmix_bass_lfe_chain dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #6 clk = ~clk;

  // Idle stretch lengths are random, with the occasional long one so that a stall
  // can span the whole pipeline.
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // About half of the frames go out back to back even in an idling phase, so
  // gaps and full-rate bursts both land on every pipeline stage.
  function automatic int pick_gap();
    if (!send_idle || $urandom_range(0, 1) == 0) return 0;
    return idle_length();
  endfunction

  function automatic sample_mode_t pick_mode(bit front);
    int r;
    r = $urandom_range(0, 9);
    if (front && r < 5) return NearLevel;
    if (r < 7) return FullScale;
    if (r == 7) return Extreme;
    if (r == 8) return ScaleEdge;
    return Quiet;
  endfunction

  // A sample for the given mode. NearLevel hovers around a level that is held
  // for a while, so the Q16 filters settle and the bass boost saturates.
  function automatic sample_t pick_sample(sample_mode_t mode, int level);
    int v;
    case (mode)
      NearLevel: v = level + int'($urandom_range(0, 1024)) - 512;
      Extreme: begin
        case ($urandom_range(0, 4))
          0: v = 32767;
          1: v = -32768;
          2: v = 0;
          3: v = -1;
          default: v = 1;
        endcase
      end
      // Around the point where the 24/5 surround gain starts to saturate.
      ScaleEdge: v = ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(6824, 6830));
      Quiet: v = int'($urandom_range(0, 64)) - 32;
      default: v = int'($urandom_range(0, 65535)) - 32768;
    endcase
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return sample_t'(v);
  endfunction

  function automatic int pick_level();
    if ($urandom_range(0, 2) == 0) return $urandom_range(0, 1) ? 32767 : -32768;
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  function automatic frame_t random_frame(int level_l, int level_r);
    frame_t f;
    f.front_left = pick_sample(pick_mode(1'b1), level_l);
    f.front_right = pick_sample(pick_mode(1'b1), level_r);
    f.center = pick_sample(pick_mode(1'b0), 0);
    f.lfe = pick_sample(pick_mode(1'b0), 0);
    f.rear_left = pick_sample(pick_mode(1'b0), 0);
    f.rear_right = pick_sample(pick_mode(1'b0), 0);
    f.marker = 1'($urandom_range(0, 1));
    return f;
  endfunction

  function automatic frame_t make_frame(int fl, int fr, int c, int lfe, int rl, int rr,
                                        bit mark);
    frame_t f;
    f.front_left = sample_t'(fl);
    f.front_right = sample_t'(fr);
    f.center = sample_t'(c);
    f.lfe = sample_t'(lfe);
    f.rear_left = sample_t'(rl);
    f.rear_right = sample_t'(rr);
    f.marker = mark;
    return f;
  endfunction

  // Presents one frame and holds it until the block takes it. Valid is only
  // dropped when a gap follows, so back-to-back frames keep it high.
  task automatic send_frame(frame_t f, int gap);
    in_ch.valid <= 1'b1;
    in_ch.front_left <= f.front_left;
    in_ch.front_right <= f.front_right;
    in_ch.center_in <= f.center;
    in_ch.lfe_in <= f.lfe;
    in_ch.rear_left <= f.rear_left;
    in_ch.rear_right <= f.rear_right;
    in_ch.block_end <= f.marker;
    do @(posedge clk); while (!in_ch.ready);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops the sender and waits until every predicted mix has come back. A clock
  // edge passes before the first check, so the monitor has logged the last transaction.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0);
  endtask

  // Only called with the pipeline empty, so no frame in flight sees the change.
  task automatic write_surround(bit en);
    cfg_ch.valid <= 1'b1;
    cfg_ch.surround_enable <= en;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  // Receiver side: ready is low in reset and high unless a stall is running.
  // A new stall may start only when stalling is enabled for the current phase.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stall_on && $urandom_range(0, 3) == 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= idle_length() - 1;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Monitor. Every accepted input frame is handed to the tracker, which runs
  // the filters and queues the expected mix; every accepted result is checked
  // against the oldest queued mix. A configuration transaction updates the
  // tracker's copy of the surround mode at the same edge the block takes it.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        tracker.set_surround(cfg_ch.surround_enable);
      end
      if (in_ch.valid && in_ch.ready) begin
        tracker.note_frame(make_frame(in_ch.front_left, in_ch.front_right, in_ch.center_in,
                                      in_ch.lfe_in, in_ch.rear_left, in_ch.rear_right,
                                      in_ch.block_end));
      end
      if (out_ch.valid && out_ch.ready) begin
        tracker.check_mix(make_frame(out_ch.front_left_out, out_ch.front_right_out,
                                     out_ch.center_out, out_ch.lfe_out,
                                     out_ch.rear_left_out, out_ch.rear_right_out,
                                     out_ch.block_last));
      end
    end
  end

  // Watchdog: any transaction on any channel restarts the count.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int phase;
    int k;
    int level_l;
    int level_r;
    bit en;

    tracker = new();
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.front_left <= '0;
    in_ch.front_right <= '0;
    in_ch.center_in <= '0;
    in_ch.lfe_in <= '0;
    in_ch.rear_left <= '0;
    in_ch.rear_right <= '0;
    in_ch.block_end <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.surround_enable <= 1'b0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, surround mode on. Covers full-scale and zero frames, the
    // boundary of the front gain of four (8191 / 8192), the boundary of the
    // surround gain (6826 / 6827), truncation toward zero for small negative
    // values, and a held level that builds up the bass filters.
    stall_on = 1'b1;
    send_idle = 1'b1;
    write_surround(1'b1);
    send_frame(make_frame(0, 0, 0, 0, 0, 0, 1'b0), pick_gap());
    send_frame(make_frame(32767, 32767, 32767, 32767, 32767, 32767, 1'b1), pick_gap());
    send_frame(make_frame(-32768, -32768, -32768, -32768, -32768, -32768, 1'b0), pick_gap());
    send_frame(make_frame(32767, -32768, 6826, 6827, -6826, -6827, 1'b1), pick_gap());
    send_frame(make_frame(-1, 1, -1, 1, 2, -2, 1'b0), pick_gap());
    send_frame(make_frame(8191, -8192, 6828, -6828, 5, -5, 1'b0), pick_gap());
    for (k = 0; k < 6; k++) begin
      send_frame(make_frame(20000, -20000, 0, 0, 0, 0, k == 5), pick_gap());
    end

    // Surround mode off: the non-front channels must pass through unchanged
    // while the front filters keep running and the LFE filter holds its state.
    wait_drained();
    write_surround(1'b0);
    send_frame(make_frame(32767, -32768, 32767, -32768, 12345, -12345, 1'b1), pick_gap());
    send_frame(make_frame(-32768, 32767, -1, 1, 0, -32768, 1'b0), pick_gap());
    send_frame(make_frame(0, 0, 0, 0, 0, 0, 1'b1), pick_gap());
    for (k = 0; k < 3; k++) begin
      send_frame(make_frame(20000, 20000, 100, -100, 7, -7, 1'b0), pick_gap());
    end

    // Back on: the LFE feed resumes from the held filter state.
    wait_drained();
    write_surround(1'b1);
    send_frame(make_frame(0, 0, 0, 0, 0, 0, 1'b0), pick_gap());
    send_frame(make_frame(-32768, -32768, 0, -32768, 0, 0, 1'b1), pick_gap());

    // Random part. Each phase starts from an empty pipeline with a new surround
    // setting (the first two phases force off and on) and its own idling mix:
    // some phases run the sender flat out, some never stall the receiver. The
    // front level is held for 80 frames at a time so the filters reach their
    // settled values, including full-scale levels where the boost saturates.
    for (phase = 0; phase < NumPhases; phase++) begin
      wait_drained();
      en = (phase < 2) ? phase[0] : 1'($urandom_range(0, 1));
      write_surround(en);
      send_idle = (phase % 4 != 0);
      stall_on = (phase % 4 != 1);
      level_l = 0;
      level_r = 0;
      for (k = 0; k < PhaseItems; k++) begin
        if (k % 80 == 0) begin
          level_l = pick_level();
          level_r = pick_level();
        end
        send_frame(random_frame(level_l, level_r), pick_gap());
        // Now and then the sender holds off until every result is back.
        if ($urandom_range(0, 199) == 0) begin
          wait_drained();
        end
      end
    end

    wait_drained();
    repeat (SettleCycles) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
